[src/lrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_pkg: shared types and constants for the line relation matcher
// Request codes, register indexes, controller states, sizes and the
// Gaussian lookup table built at elaboration.
// ----------------------------------------------------------------------------
package lrm_pkg;

  // Sizes
  localparam int MAX_SCAN_REL   = 64;
  localparam int SCAN_AW        = (MAX_SCAN_REL > 1) ? $clog2(MAX_SCAN_REL) : 1;
  localparam int SCAN_CW        = $clog2(MAX_SCAN_REL + 1);
  localparam int RANK_K         = 5;
  localparam int RANK_AW        = (RANK_K > 1) ? $clog2(RANK_K) : 1;
  localparam int MAX_SUBMAPS    = 1024;
  localparam int SUB_W          = $clog2(MAX_SUBMAPS);
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_AW         = $clog2(EXP_TABLE_SIZE);
  // x is Q.16 below 16.0 (20 bits); index = round(x * size / 2^20)
  localparam int EXP_SHIFT      = 20 - EXP_AW;
  localparam int SQRT_STAGES    = 16;

  // Field widths
  localparam int ANG_W   = 15;
  localparam int DIST_W  = 16;
  localparam int WGT_W   = 16;
  localparam int SCALE_W = 24;
  localparam int SCORE_W = 32;
  localparam int G_W     = 17;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 3;
  localparam int ENTRY_W = ANG_W + DIST_W + WGT_W;

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_SCAN   = 2'd1,
    REQ_DB     = 2'd2,
    REQ_REPORT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_PARALLEL_LIMIT = 2'd0,
    CFG_ANGLE_SCALE    = 2'd1,
    CFG_DIST_SCALE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  typedef logic [G_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

  // Taylor terms of exp(-16 / size) in Q2.30, each one truncated
  localparam longint unsigned EXP_ONE = 64'd1 << 30;
  localparam longint unsigned EXP_Y   = (64'd16 << 30) / EXP_TABLE_SIZE;
  localparam longint unsigned EXP_T1  = ((EXP_ONE * EXP_Y) >> 30) / 1;
  localparam longint unsigned EXP_T2  = ((EXP_T1  * EXP_Y) >> 30) / 2;
  localparam longint unsigned EXP_T3  = ((EXP_T2  * EXP_Y) >> 30) / 3;
  localparam longint unsigned EXP_T4  = ((EXP_T3  * EXP_Y) >> 30) / 4;
  localparam longint unsigned EXP_T5  = ((EXP_T4  * EXP_Y) >> 30) / 5;
  localparam longint unsigned EXP_T6  = ((EXP_T5  * EXP_Y) >> 30) / 6;
  localparam longint unsigned EXP_T7  = ((EXP_T6  * EXP_Y) >> 30) / 7;
  localparam longint unsigned EXP_T8  = ((EXP_T7  * EXP_Y) >> 30) / 8;
  localparam longint unsigned EXP_T9  = ((EXP_T8  * EXP_Y) >> 30) / 9;
  localparam longint unsigned EXP_T10 = ((EXP_T9  * EXP_Y) >> 30) / 10;
  localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_Y) >> 30) / 11;
  localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_Y) >> 30) / 12;
  localparam longint unsigned EXP_T13 = ((EXP_T12 * EXP_Y) >> 30) / 13;
  localparam longint unsigned EXP_T14 = ((EXP_T13 * EXP_Y) >> 30) / 14;
  localparam longint unsigned EXP_T15 = ((EXP_T14 * EXP_Y) >> 30) / 15;
  localparam longint unsigned EXP_T16 = ((EXP_T15 * EXP_Y) >> 30) / 16;
  localparam longint unsigned EXP_T17 = ((EXP_T16 * EXP_Y) >> 30) / 17;
  localparam longint unsigned EXP_T18 = ((EXP_T17 * EXP_Y) >> 30) / 18;
  localparam longint unsigned EXP_T19 = ((EXP_T18 * EXP_Y) >> 30) / 19;
  localparam longint unsigned EXP_T20 = ((EXP_T19 * EXP_Y) >> 30) / 20;
  localparam longint unsigned EXP_T21 = ((EXP_T20 * EXP_Y) >> 30) / 21;
  localparam longint unsigned EXP_T22 = ((EXP_T21 * EXP_Y) >> 30) / 22;
  localparam longint unsigned EXP_T23 = ((EXP_T22 * EXP_Y) >> 30) / 23;
  localparam longint unsigned EXP_T24 = ((EXP_T23 * EXP_Y) >> 30) / 24;
  localparam longint unsigned EXP_POS = EXP_ONE + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8 +
                                        EXP_T10 + EXP_T12 + EXP_T14 + EXP_T16 +
                                        EXP_T18 + EXP_T20 + EXP_T22 + EXP_T24;
  localparam longint unsigned EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9 +
                                        EXP_T11 + EXP_T13 + EXP_T15 + EXP_T17 +
                                        EXP_T19 + EXP_T21 + EXP_T23;
  localparam longint unsigned EXP_R   = (EXP_POS > EXP_NEG) ? EXP_POS - EXP_NEG : 64'd0;

  // exp(-16 i / size) in Q1.16, stepping by the ratio above
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned t;
    t = EXP_ONE;
    for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
      tab[i] = G_W'((t + (64'd1 << 13)) >> 14);
      t      = (t * EXP_R + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[src/line_relation_match_topk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_relation_match_topk: line relation matcher with top-K submap ranking
// Scan relations go into an on-chip store; each database relation is scored
// against every stored one and per-submap sums feed a K-entry ranking.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | content
//  in_     | in  | tvalid/tready    | tuser req_type, tdata relation, tlast end of submap
//  out_    | out | tvalid/tready    | tdata ranking slot, tlast final slot
//  cfg_    | in  | wr_en            | addr register index, wdata value
//
//  A report loads one slot per cycle into the output register while the output
//  is not stalled. A database request makes one store read per cycle into the
//  sqrt / Gaussian pipeline, then the pipeline drains and, if the request ends
//  a submap, the submap sum is ranked.
//  Reset is synchronous and needs no clearing pass; the store is read only
//  below the fill count. A stalled output holds its slot and the report.
// ----------------------------------------------------------------------------
module line_relation_match_topk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // rel_angle[14:0], rel_dist[30:15], rel_weight[46:31]
  input  logic [1:0]  in_tuser,   // req_type
  input  logic        in_tlast,   // last_of_submap
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // rank_position[2:0], submap_index[12:3], score[44:13]
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int AW = lrm_pkg::ANG_W;
  localparam int DW = lrm_pkg::DIST_W;
  localparam int WW = lrm_pkg::WGT_W;
  localparam int GW = lrm_pkg::G_W;
  localparam int SW = lrm_pkg::SCORE_W;
  localparam int NS = lrm_pkg::SQRT_STAGES;

  typedef struct packed {
    logic          vld;
    logic [31:0]   rem;
    logic [31:0]   res;
    logic [AW-1:0] da;
    logic [DW-1:0] dd;
    logic          par;
  } sq_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] s;
    logic [31:0] d2a;
    logic [31:0] d2d;
    logic        par;
  } g1_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] s;
    logic [43:0] pha;
    logic [43:0] pla;
    logic [43:0] phd;
    logic [43:0] pld;
    logic        par;
  } g2_t;

  typedef struct packed {
    logic          vld;
    logic [15:0]   s;
    logic [GW-1:0] ga;
    logic [GW-1:0] gd;
    logic          par;
  } g3_t;

  typedef struct packed {
    logic          vld;
    logic [GW-1:0] sc;
    logic [GW-1:0] gd;
    logic          par;
  } g4_t;

  typedef struct packed {
    logic          vld;
    logic [GW-1:0] sc;
  } g5_t;

  // Configuration registers
  logic [AW-1:0]                   par_lim_r;
  logic [lrm_pkg::SCALE_W-1:0]     ag_scale_r;
  logic [lrm_pkg::SCALE_W-1:0]     dg_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_lim_r  <= AW'(512);
      ag_scale_r <= lrm_pkg::SCALE_W'(32768);
      dg_scale_r <= lrm_pkg::SCALE_W'(819200);
    end else if (cfg_wr_en) begin
      unique case (lrm_pkg::cfg_idx_t'(cfg_addr))
        lrm_pkg::CFG_PARALLEL_LIMIT: par_lim_r  <= cfg_wdata[AW-1:0];
        lrm_pkg::CFG_ANGLE_SCALE:    ag_scale_r <= cfg_wdata;
        lrm_pkg::CFG_DIST_SCALE:     dg_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input field split
  logic [AW-1:0] in_ang;
  logic [DW-1:0] in_dist;
  logic [WW-1:0] in_wgt;
  lrm_pkg::req_t in_req;
  assign in_ang  = in_tdata[14:0];
  assign in_dist = in_tdata[30:15];
  assign in_wgt  = in_tdata[46:31];
  assign in_req  = lrm_pkg::req_t'(in_tuser);

  // Controller state and held request
  lrm_pkg::state_t                 state_r, state_nxt;
  logic [lrm_pkg::SCAN_CW-1:0]     scan_cnt_r;
  logic [lrm_pkg::SCAN_CW-1:0]     iss_cnt_r;
  logic [lrm_pkg::SUB_W-1:0]       sub_cnt_r;
  logic [SW-1:0]                   acc_r;
  logic [SW-1:0]                   rank_score_r [lrm_pkg::RANK_K];
  logic [lrm_pkg::SUB_W-1:0]       rank_idx_r   [lrm_pkg::RANK_K];
  logic [lrm_pkg::RANK_AW-1:0]     rp_cnt_r;
  logic [AW-1:0]                   q_ang_r;
  logic [DW-1:0]                   q_dist_r;
  logic [WW-1:0]                   q_wgt_r;
  logic                            q_last_r;

  logic in_acc;
  logic issue;
  logic busy;
  logic rank_upd;
  logic out_load;
  logic rp_end;

  assign in_acc = in_tvalid && in_tready;
  assign rp_end = (rp_cnt_r == lrm_pkg::RANK_AW'(lrm_pkg::RANK_K - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrm_pkg::ST_IDLE: begin
        if (in_acc && in_req == lrm_pkg::REQ_DB)     state_nxt = lrm_pkg::ST_STREAM;
        if (in_acc && in_req == lrm_pkg::REQ_REPORT) state_nxt = lrm_pkg::ST_REPORT;
      end
      lrm_pkg::ST_STREAM: if (iss_cnt_r == scan_cnt_r) state_nxt = lrm_pkg::ST_DRAIN;
      lrm_pkg::ST_DRAIN:  if (!busy) state_nxt = lrm_pkg::ST_IDLE;
      lrm_pkg::ST_REPORT: if (out_load && rp_end) state_nxt = lrm_pkg::ST_IDLE;
      default:            state_nxt = lrm_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    rank_upd  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      lrm_pkg::ST_IDLE:   in_tready = 1'b1;
      lrm_pkg::ST_STREAM: issue     = (iss_cnt_r != scan_cnt_r);
      lrm_pkg::ST_DRAIN:  rank_upd  = !busy && q_last_r;
      lrm_pkg::ST_REPORT: out_load  = !out_tvalid || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lrm_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Scan store: one synchronous memory of {weight, dist, angle}
  logic [lrm_pkg::ENTRY_W-1:0] scan_mem [lrm_pkg::MAX_SCAN_REL];
  logic [lrm_pkg::ENTRY_W-1:0] mem_rd_r;
  logic                        rd_vld_r;
  logic                        mem_we;

  assign mem_we = in_acc && in_req == lrm_pkg::REQ_SCAN &&
                  scan_cnt_r < lrm_pkg::SCAN_CW'(lrm_pkg::MAX_SCAN_REL);

  always_ff @(posedge clk) begin
    if (mem_we) scan_mem[scan_cnt_r[lrm_pkg::SCAN_AW-1:0]] <= {in_wgt, in_dist, in_ang};
    mem_rd_r <= scan_mem[iss_cnt_r[lrm_pkg::SCAN_AW-1:0]];
  end

  // Request capture, counters
  always_ff @(posedge clk) begin
    if (in_acc && in_req == lrm_pkg::REQ_DB) begin
      q_ang_r  <= in_ang;
      q_dist_r <= in_dist;
      q_wgt_r  <= in_wgt;
      q_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      iss_cnt_r  <= '0;
      rd_vld_r   <= 1'b0;
      rp_cnt_r   <= '0;
    end else begin
      rd_vld_r <= issue;
      if (in_acc && in_req == lrm_pkg::REQ_BEGIN) scan_cnt_r <= '0;
      else if (mem_we)                            scan_cnt_r <= scan_cnt_r + 1'b1;
      if (in_acc)     iss_cnt_r <= '0;
      else if (issue) iss_cnt_r <= iss_cnt_r + 1'b1;
      if (in_acc)        rp_cnt_r <= '0;
      else if (out_load) rp_cnt_r <= rp_cnt_r + 1'b1;
    end
  end

  // Front stage: weight product, differences, parallel test
  logic [AW-1:0] s_ang;
  logic [DW-1:0] s_dist;
  logic [WW-1:0] s_wgt;
  assign s_ang  = mem_rd_r[AW-1:0];
  assign s_dist = mem_rd_r[AW+DW-1:AW];
  assign s_wgt  = mem_rd_r[lrm_pkg::ENTRY_W-1:AW+DW];

  function automatic sq_t sq_step(sq_t a, int unsigned sh);
    sq_t         b;
    logic [31:0] bit_v;
    logic [31:0] trial;
    b     = a;
    bit_v = 32'd1 << sh;
    trial = a.res + bit_v;
    if (a.rem >= trial) begin
      b.rem = a.rem - trial;
      b.res = (a.res >> 1) + bit_v;
    end else begin
      b.res = a.res >> 1;
    end
    return b;
  endfunction

  // Square root pipeline, one result bit per stage
  sq_t sq_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) sq_r[i].vld <= 1'b0;
    end else begin
      sq_r[0].vld <= rd_vld_r;
      for (int i = 0; i < NS; i++) sq_r[i+1] <= sq_step(sq_r[i], 30 - 2 * i);
    end
    sq_r[0].rem <= 32'(q_wgt_r) * 32'(s_wgt);
    sq_r[0].res <= '0;
    sq_r[0].da  <= (q_ang_r > s_ang) ? q_ang_r - s_ang : s_ang - q_ang_r;
    sq_r[0].dd  <= (q_dist_r > s_dist) ? q_dist_r - s_dist : s_dist - q_dist_r;
    sq_r[0].par <= (q_ang_r <= par_lim_r) && (s_ang <= par_lim_r);
  end

  // Gaussian lanes and pair score
  g1_t g1_r;
  g2_t g2_r;
  g3_t g3_r;
  g4_t g4_r;
  g5_t g5_r;

  function automatic logic [GW-1:0] gauss_lookup(logic [43:0] ph, logic [43:0] pl);
    logic [55:0]             full;
    logic [39:0]             x;
    logic [20:0]             rnd;
    logic [lrm_pkg::EXP_AW:0] idx;
    logic [GW-1:0]           g;
    full = {ph, 12'd0} + 56'(pl);
    x    = full[55:16];
    rnd  = 21'(x[19:0]) + 21'(1 << (lrm_pkg::EXP_SHIFT - 1));
    idx  = rnd[20:lrm_pkg::EXP_SHIFT];
    g    = '0;
    if (x[39:20] == '0 && !idx[lrm_pkg::EXP_AW])
      g = lrm_pkg::EXP_TAB[idx[lrm_pkg::EXP_AW-1:0]];
    return g;
  endfunction

  logic [32:0] sc_a;
  logic [32:0] sc_d;
  logic [32:0] acc_sum;
  assign sc_a    = 33'(g3_r.s) * 33'(g3_r.ga);
  assign sc_d    = 33'(g4_r.sc) * 33'(g4_r.gd);
  assign acc_sum = 33'(acc_r) + 33'(g5_r.sc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r.vld <= 1'b0;
      g2_r.vld <= 1'b0;
      g3_r.vld <= 1'b0;
      g4_r.vld <= 1'b0;
      g5_r.vld <= 1'b0;
    end else begin
      g1_r.vld <= sq_r[NS].vld;
      g2_r.vld <= g1_r.vld;
      g3_r.vld <= g2_r.vld;
      g4_r.vld <= g3_r.vld;
      g5_r.vld <= g4_r.vld;
    end
    g1_r.s   <= sq_r[NS].res[15:0];
    g1_r.d2a <= 32'(sq_r[NS].da) * 32'(sq_r[NS].da);
    g1_r.d2d <= 32'(sq_r[NS].dd) * 32'(sq_r[NS].dd);
    g1_r.par <= sq_r[NS].par;
    // scale split in two 12-bit halves
    g2_r.s   <= g1_r.s;
    g2_r.pha <= 44'(g1_r.d2a) * 44'(ag_scale_r[23:12]);
    g2_r.pla <= 44'(g1_r.d2a) * 44'(ag_scale_r[11:0]);
    g2_r.phd <= 44'(g1_r.d2d) * 44'(dg_scale_r[23:12]);
    g2_r.pld <= 44'(g1_r.d2d) * 44'(dg_scale_r[11:0]);
    g2_r.par <= g1_r.par;
    g3_r.s   <= g2_r.s;
    g3_r.ga  <= gauss_lookup(g2_r.pha, g2_r.pla);
    g3_r.gd  <= gauss_lookup(g2_r.phd, g2_r.pld);
    g3_r.par <= g2_r.par;
    g4_r.sc  <= sc_a[GW+15:16];
    g4_r.gd  <= g3_r.gd;
    g4_r.par <= g3_r.par;
    g5_r.sc  <= g4_r.par ? sc_d[GW+15:16] : g4_r.sc;
  end

  logic sq_busy_mid;
  always_comb begin
    sq_busy_mid = 1'b0;
    for (int i = 0; i <= NS; i++) sq_busy_mid = sq_busy_mid | sq_r[i].vld;
  end

  assign busy = rd_vld_r || g1_r.vld || g2_r.vld || g3_r.vld || g4_r.vld || g5_r.vld ||
                sq_busy_mid;

  // Ranking insert: compares against every slot in parallel, list stays sorted
  logic [lrm_pkg::RANK_K-1:0] gt;
  logic                       enter;
  always_comb begin
    for (int k = 0; k < lrm_pkg::RANK_K; k++) gt[k] = rank_score_r[k] < acc_r;
    enter = gt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_req == lrm_pkg::REQ_BEGIN)) begin
      acc_r     <= '0;
      sub_cnt_r <= '0;
      for (int k = 0; k < lrm_pkg::RANK_K; k++) begin
        rank_score_r[k] <= '0;
        rank_idx_r[k]   <= '0;
      end
    end else if (rank_upd) begin
      acc_r     <= '0;
      sub_cnt_r <= sub_cnt_r + 1'b1;
      if (enter) begin
        for (int k = 0; k < lrm_pkg::RANK_K; k++) begin
          if (k + 1 < lrm_pkg::RANK_K && gt[(k + 1) % lrm_pkg::RANK_K]) begin
            rank_score_r[k] <= rank_score_r[(k + 1) % lrm_pkg::RANK_K];
            rank_idx_r[k]   <= rank_idx_r[(k + 1) % lrm_pkg::RANK_K];
          end else if (gt[k]) begin
            rank_score_r[k] <= acc_r;
            rank_idx_r[k]   <= sub_cnt_r;
          end
        end
      end
    end else if (g5_r.vld) begin
      acc_r <= acc_sum[32] ? '1 : acc_sum[31:0];
    end
  end

  // Output register
  logic                          out_vld_r;
  logic [lrm_pkg::POS_W-1:0]     out_pos_r;
  logic [lrm_pkg::IDX_W-1:0]     out_idx_r;
  logic [SW-1:0]                 out_score_r;
  logic                          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)        out_vld_r <= 1'b0;
    else if (out_load) out_vld_r <= 1'b1;
    else if (out_tready) out_vld_r <= 1'b0;
    if (out_load) begin
      out_pos_r   <= lrm_pkg::POS_W'(rp_cnt_r);
      out_idx_r   <= lrm_pkg::IDX_W'(rank_idx_r[rp_cnt_r]);
      out_score_r <= rank_score_r[rp_cnt_r];
      out_last_r  <= rp_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'd0, out_score_r, out_idx_r, out_pos_r};
  assign out_tlast  = out_last_r;

  // Checks
  logic rank_sorted;
  always_comb begin
    rank_sorted = 1'b1;
    for (int k = 0; k + 1 < lrm_pkg::RANK_K; k++)
      rank_sorted = rank_sorted &&
                    (rank_score_r[k] <= rank_score_r[(k + 1) % lrm_pkg::RANK_K]);
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lrm_pkg::ST_IDLE |-> !busy)
    else $error("pipeline active while controller idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= lrm_pkg::SCAN_CW'(lrm_pkg::MAX_SCAN_REL))
    else $error("scan fill count beyond store depth");

  a_rank_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    rank_sorted)
    else $error("ranking out of order");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> iss_cnt_r < scan_cnt_r)
    else $error("store read beyond fill count");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for line_relation_match_topk
// Streams begin, scan, database and report requests with random idling on
// both sides. A behavioral score model predicts each ranking slot and the
// monitor compares every output slot field by field.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    lrm_pkg::req_t                rtype;
    logic [lrm_pkg::ANG_W-1:0]    angle;
    logic [lrm_pkg::DIST_W-1:0]   spacing;
    logic [lrm_pkg::WGT_W-1:0]    weight;
    logic                         sub_end;
  } rel_req_t;

  typedef struct packed {
    logic [lrm_pkg::POS_W-1:0]   pos;
    logic [lrm_pkg::IDX_W-1:0]   submap;
    logic [lrm_pkg::SCORE_W-1:0] score;
    logic                        last;
  } slot_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  line_relation_match_topk i_dut (.*);

  // Behavioral copy of the matcher state
  logic [16:0]                 gauss_tab [lrm_pkg::EXP_TABLE_SIZE];
  logic [14:0]                 par_limit;
  logic [23:0]                 ang_scale;
  logic [23:0]                 dist_scale;
  logic [lrm_pkg::ANG_W-1:0]   st_angle [lrm_pkg::MAX_SCAN_REL];
  logic [lrm_pkg::DIST_W-1:0]  st_dist [lrm_pkg::MAX_SCAN_REL];
  logic [lrm_pkg::WGT_W-1:0]   st_weight [lrm_pkg::MAX_SCAN_REL];
  int                          scan_fill;
  int                          sub_ctr;
  logic [31:0]                 submap_sum;
  logic [31:0]                 top_score [lrm_pkg::RANK_K];
  logic [lrm_pkg::IDX_W-1:0]   top_index [lrm_pkg::RANK_K];

  rel_req_t pending_reqs[$];
  slot_t    expected_slots[$];
  int       errors;
  bit       drive_idle_en;
  bit       hold_rx;

  function automatic void fill_gauss_tab();
    longint unsigned y, term, pos, neg, r, t;
    y = (64'd16 << 30) / lrm_pkg::EXP_TABLE_SIZE;
    term = 64'd1 << 30;
    pos = term;
    neg = 0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 30) / k;
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    r = (pos > neg) ? pos - neg : 0;
    t = 64'd1 << 30;
    for (int i = 0; i < lrm_pkg::EXP_TABLE_SIZE; i++) begin
      gauss_tab[i] = 17'((t + (64'd1 << 13)) >> 14);
      t = (t * r + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned gauss_weight(longint unsigned a, longint unsigned b,
                                                   longint unsigned scale);
    longint unsigned d, x, idx;
    d = (a > b) ? a - b : b - a;
    x = (d * d * scale) >> 16;
    if (x >= (64'd16 << 16)) return 0;
    idx = (x * lrm_pkg::EXP_TABLE_SIZE + (64'd1 << 19)) >> 20;
    if (idx >= lrm_pkg::EXP_TABLE_SIZE) return 0;
    return gauss_tab[idx];
  endfunction

  task automatic write_reg(lrm_pkg::cfg_idx_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      lrm_pkg::CFG_PARALLEL_LIMIT: par_limit = val[14:0];
      lrm_pkg::CFG_ANGLE_SCALE:    ang_scale = val;
      default:                     dist_scale = val;
    endcase
  endtask

  // Predict the ranking slots caused by one accepted request
  task automatic score_request(rel_req_t rq);
    longint unsigned s, acc;
    logic [31:0] ts;
    logic [lrm_pkg::IDX_W-1:0] ti;
    slot_t sl;
    case (rq.rtype)
      lrm_pkg::REQ_BEGIN: begin
        scan_fill = 0;
        sub_ctr = 0;
        submap_sum = 0;
        for (int k = 0; k < lrm_pkg::RANK_K; k++) begin
          top_score[k] = 0;
          top_index[k] = 0;
        end
      end
      lrm_pkg::REQ_SCAN: begin
        if (scan_fill < lrm_pkg::MAX_SCAN_REL) begin
          st_angle[scan_fill] = rq.angle;
          st_dist[scan_fill] = rq.spacing;
          st_weight[scan_fill] = rq.weight;
          scan_fill++;
        end
      end
      lrm_pkg::REQ_DB: begin
        for (int i = 0; i < scan_fill; i++) begin
          s = int_sqrt(longint'(rq.weight) * st_weight[i]);
          s = (s * gauss_weight(rq.angle, st_angle[i], ang_scale)) >> 16;
          if (rq.angle <= par_limit && st_angle[i] <= par_limit)
            s = (s * gauss_weight(rq.spacing, st_dist[i], dist_scale)) >> 16;
          acc = longint'(submap_sum) + s;
          submap_sum = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        end
        if (rq.sub_end) begin
          if (submap_sum > top_score[0]) begin
            top_score[0] = submap_sum;
            top_index[0] = sub_ctr[lrm_pkg::IDX_W-1:0];
            for (int k = 0; k + 1 < lrm_pkg::RANK_K; k++) begin
              if (top_score[k] <= top_score[k+1]) break;
              ts = top_score[k+1];
              ti = top_index[k+1];
              top_score[k+1] = top_score[k];
              top_index[k+1] = top_index[k];
              top_score[k] = ts;
              top_index[k] = ti;
            end
          end
          submap_sum = 0;
          sub_ctr = (sub_ctr + 1) % lrm_pkg::MAX_SUBMAPS;
        end
      end
      default: begin
        for (int k = 0; k < lrm_pkg::RANK_K; k++) begin
          sl.pos = lrm_pkg::POS_W'(k);
          sl.submap = top_index[k];
          sl.score = top_score[k];
          sl.last = (k == lrm_pkg::RANK_K - 1);
          expected_slots.insert(expected_slots.size(), sl);
        end
      end
    endcase
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #80ms;
    $display("TEST FAILED");
    $finish;
  end

  // Driver: presents queued requests with random gaps
  int gap_cnt;
  rel_req_t cur_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_tvalid && in_tready) score_request(cur_req);
      if (!in_tvalid || in_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (drive_idle_en && $urandom_range(0, 5) == 0) begin
            gap_cnt = $urandom_range(1, 9) - 1;
            in_tvalid <= 1'b0;
          end else begin
            cur_req = pending_reqs.pop_front();
            in_tvalid <= 1'b1;
            in_tuser  <= cur_req.rtype;
            in_tlast  <= cur_req.sub_end;
            in_tdata  <= {1'b0, cur_req.weight, cur_req.spacing, cur_req.angle};
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure
  int stall_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_cnt = 0;
    end else if (hold_rx) begin
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else if (drive_idle_en && $urandom_range(0, 4) == 0) begin
      stall_cnt = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compares each slot against the oldest prediction
  slot_t got, exp_sl;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.pos = out_tdata[2:0];
      got.submap = out_tdata[12:3];
      got.score = out_tdata[44:13];
      got.last = out_tlast;
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected slot pos=%0d idx=%0d score=%h", $time,
                 got.pos, got.submap, got.score);
        errors++;
      end else begin
        exp_sl = expected_slots.pop_front();
        if (got.pos !== exp_sl.pos) begin
          $display("%0t: rank_position exp %0d got %0d", $time, exp_sl.pos, got.pos);
          errors++;
        end
        if (got.submap !== exp_sl.submap) begin
          $display("%0t: submap_index exp %0d got %0d", $time, exp_sl.submap, got.submap);
          errors++;
        end
        if (got.score !== exp_sl.score) begin
          $display("%0t: score exp %h got %h", $time, exp_sl.score, got.score);
          errors++;
        end
        if (got.last !== exp_sl.last) begin
          $display("%0t: last exp %0d got %0d", $time, exp_sl.last, got.last);
          errors++;
        end
      end
    end
  end

  function automatic rel_req_t mk_req(lrm_pkg::req_t t, int a, int d, int w, bit e);
    rel_req_t r;
    r.rtype = t;
    r.angle = lrm_pkg::ANG_W'(a);
    r.spacing = lrm_pkg::DIST_W'(d);
    r.weight = lrm_pkg::WGT_W'(w);
    r.sub_end = e;
    return r;
  endfunction

  function automatic rel_req_t rand_rel(lrm_pkg::req_t t, bit e);
    int a;
    // angles mostly near the parallel region so both branches get hit
    a = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 23040);
    if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 32767);
    return mk_req(t, a, $urandom_range(0, 65535), $urandom_range(0, 65535), e);
  endfunction

  task automatic queue_req(rel_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || in_tvalid || expected_slots.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // One query: begin, scan set, several submaps, report
  task automatic queue_query(int n_scan, int n_sub, int db_max);
    queue_req(mk_req(lrm_pkg::REQ_BEGIN, 0, 0, 0, $urandom_range(0, 1)));
    for (int i = 0; i < n_scan; i++)
      queue_req(rand_rel(lrm_pkg::REQ_SCAN, $urandom_range(0, 1)));
    for (int s = 0; s < n_sub; s++) begin
      int n_db;
      n_db = $urandom_range(1, db_max);
      for (int j = 0; j < n_db; j++)
        queue_req(rand_rel(lrm_pkg::REQ_DB, j == n_db - 1));
      if ($urandom_range(0, 7) == 0)
        queue_req(rand_rel(lrm_pkg::REQ_REPORT, $urandom_range(0, 1)));
    end
    queue_req(rand_rel(lrm_pkg::REQ_REPORT, 0));
  endtask

  initial begin
    int hold_cycles;
    errors = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = lrm_pkg::REQ_BEGIN;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = lrm_pkg::CFG_PARALLEL_LIMIT;
    cfg_wdata = '0;
    drive_idle_en = 1'b1;
    hold_rx = 1'b0;
    fill_gauss_tab();
    par_limit = 512;
    ang_scale = 32768;
    dist_scale = 819200;
    scan_fill = 0;
    sub_ctr = 0;
    submap_sum = 0;
    for (int k = 0; k < lrm_pkg::RANK_K; k++) begin
      top_score[k] = 0;
      top_index[k] = 0;
    end
    @(posedge rst_n);

    // Directed: report before anything, empty store, field extremes, ties
    queue_req(mk_req(lrm_pkg::REQ_REPORT, 0, 0, 0, 0));
    queue_req(mk_req(lrm_pkg::REQ_BEGIN, 32767, 65535, 65535, 1));
    queue_req(mk_req(lrm_pkg::REQ_DB, 100, 5, 65535, 1));
    queue_req(mk_req(lrm_pkg::REQ_SCAN, 0, 0, 65535, 0));
    queue_req(mk_req(lrm_pkg::REQ_SCAN, 32767, 65535, 65535, 1));
    queue_req(mk_req(lrm_pkg::REQ_SCAN, 512, 256, 0, 0));
    queue_req(mk_req(lrm_pkg::REQ_DB, 0, 0, 65535, 0));
    queue_req(mk_req(lrm_pkg::REQ_DB, 512, 0, 65535, 1));
    queue_req(mk_req(lrm_pkg::REQ_DB, 0, 0, 65535, 1));   // first relation of the previous submap alone
    queue_req(mk_req(lrm_pkg::REQ_DB, 32767, 65535, 0, 1));
    queue_req(mk_req(lrm_pkg::REQ_DB, 513, 300, 40000, 1));
    queue_req(mk_req(lrm_pkg::REQ_DB, 23040, 65535, 65535, 1));
    queue_req(mk_req(lrm_pkg::REQ_REPORT, 32767, 65535, 65535, 1));
    wait_quiet();

    // Full store: zero Gaussian scales give full weight per pair
    write_reg(lrm_pkg::CFG_ANGLE_SCALE, 24'd0);
    write_reg(lrm_pkg::CFG_DIST_SCALE, 24'd0);
    write_reg(lrm_pkg::CFG_PARALLEL_LIMIT, 24'd23040);
    queue_req(mk_req(lrm_pkg::REQ_BEGIN, 0, 0, 0, 0));
    for (int i = 0; i < 66; i++)
      queue_req(mk_req(lrm_pkg::REQ_SCAN, i, i, 65535, 0));  // past store limit
    for (int j = 0; j < 49; j++)
      queue_req(mk_req(lrm_pkg::REQ_DB, 0, 0, 65535, (j % 12) == 11));
    queue_req(mk_req(lrm_pkg::REQ_DB, 0, 0, 65535, 1));
    queue_req(mk_req(lrm_pkg::REQ_REPORT, 0, 0, 0, 0));
    wait_quiet();

    // Random queries over several register settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(lrm_pkg::CFG_PARALLEL_LIMIT, 24'd512);
          write_reg(lrm_pkg::CFG_ANGLE_SCALE, 24'd32768);
          write_reg(lrm_pkg::CFG_DIST_SCALE, 24'd819200);
        end
        1: begin
          write_reg(lrm_pkg::CFG_PARALLEL_LIMIT, 24'd0);
          write_reg(lrm_pkg::CFG_ANGLE_SCALE, 24'hFFFFFF);
          write_reg(lrm_pkg::CFG_DIST_SCALE, 24'd1);
        end
        2: begin
          write_reg(lrm_pkg::CFG_PARALLEL_LIMIT, 24'h7FFF);
          write_reg(lrm_pkg::CFG_ANGLE_SCALE, 24'd40);
          write_reg(lrm_pkg::CFG_DIST_SCALE, 24'hFFFFFF);
        end
        default: begin
          write_reg(lrm_pkg::CFG_PARALLEL_LIMIT, 24'($urandom_range(0, 23040)));
          write_reg(lrm_pkg::CFG_ANGLE_SCALE, 24'($urandom_range(1, 4000)));
          write_reg(lrm_pkg::CFG_DIST_SCALE, 24'($urandom_range(1, 200000)));
          drive_idle_en = 1'b0;
        end
      endcase
      for (int q = 0; q < 2; q++) begin
        queue_query($urandom_range(1, 12), $urandom_range(3, 9), 4);
        if (phase == 1 && q == 0) begin
          // receiver holds off while requests keep coming
          hold_rx = 1'b1;
          for (int m = 0; m < 3; m++) queue_req(mk_req(lrm_pkg::REQ_REPORT, 0, 0, 0, 0));
          hold_cycles = 0;
          while (hold_cycles < 400) begin
            @(posedge clk);
            hold_cycles++;
          end
          hold_rx = 1'b0;
        end
      end
      wait_quiet();
    end

    wait_quiet();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
